@@ sv/tkpd_pkg.sv @@
// tkpd_pkg: constants and helper functions for the tag key / password derivation.
// Holds the fixed base words and the round mix. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tkpd_pkg;

  typedef logic [31:0] word_t;

  // Key base, words 1..5 (byte 7 of word 1 is fixed, identifier fills the rest)
  localparam logic [7:0] KeyByte7  = 8'hb7;
  localparam word_t      KeyWord2  = 32'he7e6d7d5;
  localparam word_t      KeyWord3  = 32'hd8a83cba;
  localparam word_t      KeyWord4  = 32'hcf684775;
  localparam word_t      KeyWord5  = 32'haafee923;
  localparam logic [7:0] ForceByte = 8'haa;

  // Text base, words 1..7
  localparam logic [7:0] TextByte7 = 8'h28;
  localparam word_t      TextWord2 = 32'h43202963;
  localparam word_t      TextWord3 = 32'h7279706f;
  localparam word_t      TextWord4 = 32'h74686769;
  localparam word_t      TextWord5 = 32'h47454c20;
  localparam word_t      TextWord6 = 32'h3032204f;
  localparam word_t      TextWord7 = 32'haaaa3431;

  // Word with its top byte forced
  function automatic word_t force_top(input word_t w);
    return {ForceByte, w[23:0]};
  endfunction

  // Carried part of one round: rotr(a,25) + rotr(a,10) - a
  function automatic word_t mix_carry(input word_t a);
    word_t r25;
    word_t r10;
    r25 = {a[24:0], a[31:25]};
    r10 = {a[9:0], a[31:10]};
    return r25 + r10 - a;
  endfunction

  function automatic word_t bswap(input word_t v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

`default_nettype wire

@@ sv/tag_key_password_derive.sv @@
// Pipeline: 7 register stages; out_valid and the result words are driven from the last
// stage.
// Throughput: one identifier per cycle; busy is never raised and results are never held.
// Reset clears the stage valid bits only; data registers are not reset.
// Stage 1 does rounds 1-2, stages 2-7 one round each of the text mix, key words tap off
// the key mix at stages 2 to 5 and ride along to the output stage.
`timescale 1ns / 1ps
`default_nettype none

module tag_key_password_derive import tkpd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [55:0] in_tag_uid,
  output logic             out_valid,
  output logic [31:0]      out_key_word_0,
  output logic [31:0]      out_key_word_1,
  output logic [31:0]      out_key_word_2,
  output logic [31:0]      out_key_word_3,
  output logic [31:0]      out_access_password
);

  localparam int Stages = 7;

  logic [Stages:1] vld_r;

  word_t tacc_r [1:Stages];
  word_t kacc_r [1:4];
  word_t key0_r [2:Stages];
  word_t key1_r [3:Stages];
  word_t key2_r [4:Stages];
  word_t key3_r [5:Stages];

  word_t w0;
  word_t c0;
  word_t kacc1_nxt;
  word_t tacc1_nxt;
  word_t kc [1:4];
  word_t tc [1:6];

  logic accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Round 1 leaves acc = w0, round 2 adds word 1 on top of the mixed w0
  assign w0        = in_tag_uid[31:0];
  assign c0        = mix_carry(w0);
  assign kacc1_nxt = {KeyByte7, in_tag_uid[55:32]} + c0;
  assign tacc1_nxt = {TextByte7, in_tag_uid[55:32]} + c0;

  always_comb begin
    for (int i = 1; i <= 4; i++) begin
      kc[i] = mix_carry(kacc_r[i]);
    end
    for (int i = 1; i <= 6; i++) begin
      tc[i] = mix_carry(tacc_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[Stages-1:1], accept};
    end
  end

  always_ff @(posedge clk) begin
    tacc_r[1] <= tacc1_nxt;
    kacc_r[1] <= kacc1_nxt;

    // Key mix: rounds 3..5 carried, key words 0..2 split off with the top byte forced
    kacc_r[2] <= kc[1] + KeyWord2;
    kacc_r[3] <= kc[2] + KeyWord3;
    kacc_r[4] <= kc[3] + KeyWord4;

    key0_r[2] <= kc[1] + force_top(KeyWord2);
    key1_r[3] <= kc[2] + force_top(KeyWord3);
    key2_r[4] <= kc[3] + force_top(KeyWord4);
    key3_r[5] <= kc[4] + KeyWord5;

    tacc_r[2] <= tc[1] + TextWord2;
    tacc_r[3] <= tc[2] + TextWord3;
    tacc_r[4] <= tc[3] + TextWord4;
    tacc_r[5] <= tc[4] + TextWord5;
    tacc_r[6] <= tc[5] + TextWord6;
    tacc_r[7] <= tc[6] + TextWord7;

    for (int i = 3; i <= Stages; i++) key0_r[i] <= key0_r[i-1];
    for (int i = 4; i <= Stages; i++) key1_r[i] <= key1_r[i-1];
    for (int i = 5; i <= Stages; i++) key2_r[i] <= key2_r[i-1];
    for (int i = 6; i <= Stages; i++) key3_r[i] <= key3_r[i-1];
  end

  assign out_valid           = vld_r[Stages];
  assign out_key_word_0      = bswap(key0_r[Stages]);
  assign out_key_word_1      = bswap(key1_r[Stages]);
  assign out_key_word_2      = bswap(key2_r[Stages]);
  assign out_key_word_3      = bswap(key3_r[Stages]);
  assign out_access_password = bswap(tacc_r[Stages]);

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// tb: self-checking bench for tag_key_password_derive.
// Needs tkpd_pkg and the block itself. Expected key words and the password
// come from an independent model of the rotate-and-add mix.
`timescale 1ns / 1ps

module tb;
  import tkpd_pkg::*;

  localparam int RandomRequests = 1400;
  localparam int IdlePercent    = 21;
  localparam int CalmFrom       = 400;   // requests in [CalmFrom, CalmTo) never idle
  localparam int CalmTo         = 700;
  localparam int DrainCycles    = 16;
  localparam int StallLimit     = 1000;
  localparam int ReportLimit    = 10;

  // Fixed bytes after the identifier, byte 7 in the low bits
  localparam logic [135:0] KeyTail  = 136'haafee923_cf684775_d8a83cba_e7e6d7d5_b7;
  localparam logic [199:0] TextTail =
      200'haaaa3431_3032204f_47454c20_74686769_7279706f_43202963_28;

  typedef struct packed {
    word_t key0;
    word_t key1;
    word_t key2;
    word_t key3;
    word_t password;
  } derived_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [55:0] in_tag_uid = '0;
  logic        busy;
  logic        out_valid;
  logic [31:0] out_key_word_0;
  logic [31:0] out_key_word_1;
  logic [31:0] out_key_word_2;
  logic [31:0] out_key_word_3;
  logic [31:0] out_access_password;

  logic [55:0] uid_q[$];
  derived_t    expected_keys_q[$];
  int          sent_count = 0;
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  bit          failed = 1'b0;

  tag_key_password_derive dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_tag_uid          (in_tag_uid),
    .out_valid           (out_valid),
    .out_key_word_0      (out_key_word_0),
    .out_key_word_1      (out_key_word_1),
    .out_key_word_2      (out_key_word_2),
    .out_key_word_3      (out_key_word_3),
    .out_access_password (out_access_password)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic word_t ror32(input word_t v, input int s);
    return (v >> s) | (v << (32 - s));
  endfunction

  // Byte 0 of the buffer sits in bits 7..0, so word i is simply bits 32i+31..32i
  function automatic word_t run_mix(input logic [255:0] buf_bytes, input int words);
    word_t acc;
    acc = '0;
    for (int i = 0; i < words; i++)
      acc = buf_bytes[32*i +: 32] + ror32(acc, 25) + ror32(acc, 10) - acc;
    return {acc[7:0], acc[15:8], acc[23:16], acc[31:24]};
  endfunction

  function automatic derived_t derive_keys(input logic [55:0] uid);
    logic [255:0] key_buf;
    logic [255:0] text_buf;
    logic [255:0] work;
    word_t        k[4];
    derived_t     d;
    key_buf  = {64'h0, KeyTail, uid};
    text_buf = {TextTail, uid};
    for (int n = 0; n < 4; n++) begin
      work = key_buf;
      work[8*(4*(3+n)-1) +: 8] = 8'haa;
      k[n] = run_mix(work, 3 + n);
    end
    d.key0     = k[0];
    d.key1     = k[1];
    d.key2     = k[2];
    d.key3     = k[3];
    d.password = run_mix(text_buf, 8);
    return d;
  endfunction

  function automatic logic [55:0] random_uid();
    logic [55:0] u;
    u = 56'({$urandom, $urandom});
    case ($urandom_range(0, 9))
      0: u = u & {7{$urandom_range(0, 1) ? 8'hff : 8'h00}};
      1: u = 56'h1 << $urandom_range(0, 55);
      2: u = ~(56'h1 << $urandom_range(0, 55));
      default: ;
    endcase
    return u;
  endfunction

  task automatic report(input string field, input word_t want, input word_t got);
    mismatch_count++;
    failed = 1'b1;
    if (mismatch_count <= ReportLimit)
      $display("mismatch %s: expected %08h got %08h", field, want, got);
  endtask

  // Driver: present a request, hold it until taken, then maybe idle
  always @(posedge clk) begin
    bit taken;
    if (rst_n) begin
      taken = start && !busy;
      if (taken)
        expected_keys_q.push_back(derive_keys(in_tag_uid));
      if (!start || taken) begin
        if (uid_q.size() != 0 &&
            ((sent_count >= CalmFrom && sent_count < CalmTo) ||
             $urandom_range(0, 99) >= IdlePercent)) begin
          start      <= 1'b1;
          in_tag_uid <= uid_q.pop_front();
          sent_count++;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: results cannot be held off, so every strobe is checked
  always @(posedge clk) begin
    derived_t want;
    if (rst_n && out_valid) begin
      if (expected_keys_q.size() == 0) begin
        mismatch_count++;
        failed = 1'b1;
        if (mismatch_count <= ReportLimit)
          $display("unexpected result: key0 %08h password %08h",
                   out_key_word_0, out_access_password);
      end else begin
        want = expected_keys_q.pop_front();
        if (out_key_word_0 !== want.key0) report("key_word_0", want.key0, out_key_word_0);
        if (out_key_word_1 !== want.key1) report("key_word_1", want.key1, out_key_word_1);
        if (out_key_word_2 !== want.key2) report("key_word_2", want.key2, out_key_word_2);
        if (out_key_word_3 !== want.key3) report("key_word_3", want.key3, out_key_word_3);
        if (out_access_password !== want.password)
          report("access_password", want.password, out_access_password);
      end
    end
  end

  // Watchdog on cycles with no request and no result moving
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("tb: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    // Directed: extremes, byte patterns and single bits
    uid_q.push_back(56'h0);
    uid_q.push_back(56'hff_ffff_ffff_ffff);
    uid_q.push_back(56'haa_aaaa_aaaa_aaaa);
    uid_q.push_back(56'h55_5555_5555_5555);
    uid_q.push_back(56'h06_0504_0302_0100);
    uid_q.push_back(56'h1);
    uid_q.push_back(56'h80_0000_0000_0000);
    uid_q.push_back(56'h7f_ffff_ffff_ffff);
    for (int b = 0; b < 7; b++) begin
      uid_q.push_back(56'hff << (8 * b));
      uid_q.push_back(~(56'hff << (8 * b)));
    end
    for (int i = 0; i < RandomRequests; i++)
      uid_q.push_back(random_uid());

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (uid_q.size() != 0 || start) @(posedge clk);
    while (expected_keys_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (expected_keys_q.size() != 0) failed = 1'b1;
    if (!failed) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
